// ===== rtl/core/pwmps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pwmps_pkg;

  localparam int CLOCK_HZ_DEF  = 16000000;
  localparam int MAX_COUNT_DEF = 65535;

  localparam int DSR_W = 17;
  localparam int OUT_W = 56;

  localparam logic [15:0] DIV_LIMIT  = 16'hFFFF;
  localparam logic [7:0]  CODE_UP    = 8'h83;
  localparam logic [7:0]  CODE_DOWN  = 8'h43;
  localparam logic [15:0] FREQ_RESET = 16'd20;
  localparam logic [7:0]  STEP_RESET = 8'd20;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  localparam logic REG_FREQUENCY    = 1'b0;
  localparam logic REG_STEP_DIVISOR = 1'b1;

  typedef enum logic [1:0] {
    SEL_FREQ = 2'd0,
    SEL_TRY  = 2'd1,
    SEL_STEP = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_n;
    logic     init_d;
    logic     inc_d;
    logic     commit;
    logic     set_fail;
    logic     btn_latch;
    logic     btn_clear;
    logic     btn_apply;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic freq_zero;
    logic quot_big;
    logic rem_zero;
    logic d_last;
    logic btn_press;
    logic held_empty;
    logic need_step;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/pwmps_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmps_div #(
  parameter int NW = 24,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  assign shifted = {remainder, quotient[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(NW);
        quotient  <= dividend;
        remainder <= '0;
        dsr       <= divisor;
      end else if (busy) begin
        if (!diff[DW+1]) begin
          remainder <= diff[DW-1:0];
          quotient  <= {quotient[NW-2:0], 1'b1};
        end else begin
          remainder <= shifted[DW-1:0];
          quotient  <= {quotient[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Divider reports done while still busy.");
  a_start_gap: assert property (@(posedge clk) disable iff (rst) start |=> !done)
    else $error("Divider finished in the cycle after start.");

endmodule

// ===== rtl/core/pwmps_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_dp
// Timer settings, button latch, shared divider and result register.
// ----------------------------------------------------------------------------
module pwmps_dp #(
  parameter int CLOCK_HZ  = pwmps_pkg::CLOCK_HZ_DEF,
  parameter int MAX_COUNT = pwmps_pkg::MAX_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pwmps_pkg::cmd_t             cmd,
  output pwmps_pkg::sts_t             sts,
  input  logic [7:0]                  port_value,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        m_ready,
  output logic                        m_valid,
  output logic [pwmps_pkg::OUT_W-1:0] m_data
);
  import pwmps_pkg::*;

  localparam int CLK_W = $clog2(CLOCK_HZ + 1);
  localparam int NW    = (CLK_W > DSR_W) ? CLK_W : DSR_W;

  logic [15:0]    frequency;
  logic [7:0]     step_divisor;
  logic [7:0]     held;
  logic [15:0]    period;
  logic [15:0]    duty;
  logic [15:0]    prescale;
  logic           fail;
  logic [NW-1:0]  n;
  logic [15:0]    d;

  logic [NW-1:0]    dividend;
  logic [DSR_W-1:0] divisor;
  logic             div_done;
  logic [NW-1:0]    quotient;
  logic [DSR_W-1:0] remainder;

  logic [15:0] step;
  logic [16:0] up_sum;
  logic [15:0] up_val;
  logic [15:0] dn_raw;
  logic [15:0] dn_val;
  logic [15:0] duty_next;

  always_comb begin
    unique case (cmd.div_sel)
      SEL_FREQ: begin
        dividend = NW'(CLOCK_HZ);
        divisor  = {1'b0, frequency};
      end
      SEL_TRY: begin
        dividend = n;
        divisor  = {1'b0, d};
      end
      SEL_STEP: begin
        dividend = NW'(period);
        divisor  = DSR_W'(step_divisor);
      end
      default: begin
        dividend = n;
        divisor  = {1'b0, d};
      end
    endcase
  end

  pwmps_div #(.NW(NW), .DW(DSR_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  assign step   = quotient[15:0];
  assign up_sum = {1'b0, duty} + {1'b0, step};
  assign up_val = (up_sum > {1'b0, period}) ? period : up_sum[15:0];
  assign dn_raw = (step > duty) ? 16'd0 : duty - step;
  assign dn_val = (dn_raw > period) ? period : dn_raw;

  always_comb begin
    if (held == CODE_UP) begin
      duty_next = up_val;
    end else if (held == CODE_DOWN) begin
      duty_next = dn_val;
    end else begin
      duty_next = duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency    <= FREQ_RESET;
      step_divisor <= STEP_RESET;
      held         <= '0;
      period       <= '0;
      duty         <= '0;
      prescale     <= '0;
      fail         <= 1'b0;
      n            <= '0;
      d            <= '0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FREQUENCY:    frequency    <= cfg_data;
          REG_STEP_DIVISOR: step_divisor <= cfg_data[7:0];
          default:          frequency    <= frequency;
        endcase
      end
      if (cmd.cap_n) begin
        n <= quotient;
      end
      if (cmd.init_d) begin
        d <= 16'd1;
      end
      if (cmd.inc_d) begin
        d <= d + 16'd1;
      end
      if (cmd.commit) begin
        prescale <= d;
        period   <= quotient[15:0];
        duty     <= {1'b0, quotient[15:1]};
        fail     <= 1'b0;
      end
      if (cmd.set_fail) begin
        fail <= 1'b1;
      end
      if (cmd.btn_latch) begin
        held <= port_value;
      end
      if (cmd.btn_clear) begin
        held <= '0;
      end
      if (cmd.btn_apply) begin
        duty <= duty_next;
        held <= '0;
      end
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_data <= {7'd0, fail, duty, period, prescale};
    end
  end

  always_comb begin
    sts.div_done   = div_done;
    sts.freq_zero  = (frequency == 16'd0);
    sts.quot_big   = (quotient > NW'(MAX_COUNT));
    sts.rem_zero   = (remainder == '0);
    sts.d_last     = (d == DIV_LIMIT);
    sts.btn_press  = !port_value[7] || !port_value[6];
    sts.held_empty = (held == 8'd0);
    sts.need_step  = ((held == CODE_UP) || (held == CODE_DOWN)) && (step_divisor != 8'd0);
    sts.out_free   = !m_valid || m_ready;
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst) duty <= period)
    else $error("Duty exceeds period.");

endmodule

// ===== rtl/core/pwmps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmps_ctrl
// Sequencer for the prescaler search and the button duty step.
// ----------------------------------------------------------------------------
module pwmps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            req_type,
  input  pwmps_pkg::sts_t sts,
  output pwmps_pkg::cmd_t cmd
);
  import pwmps_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_N_GO   = 8'b00000010,
    S_N_WAIT = 8'b00000100,
    S_T_GO   = 8'b00001000,
    S_T_WAIT = 8'b00010000,
    S_S_GO   = 8'b00100000,
    S_S_WAIT = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_FREQ;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_START) begin
            if (sts.freq_zero) begin
              cmd.set_fail = 1'b1;
              state_next   = S_OUT;
            end else begin
              state_next = S_N_GO;
            end
          end else if (sts.btn_press) begin
            cmd.btn_latch = 1'b1;
            state_next    = S_OUT;
          end else if (sts.held_empty) begin
            state_next = S_OUT;
          end else if (sts.need_step) begin
            state_next = S_S_GO;
          end else begin
            cmd.btn_clear = 1'b1;
            state_next    = S_OUT;
          end
        end
      end
      S_N_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_FREQ;
        state_next    = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_n  = 1'b1;
          cmd.init_d = 1'b1;
          state_next = S_T_GO;
        end
      end
      S_T_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_TRY;
        state_next    = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero && !sts.quot_big) begin
            cmd.commit = 1'b1;
            state_next = S_OUT;
          end else if (sts.d_last) begin
            cmd.set_fail = 1'b1;
            state_next   = S_OUT;
          end else begin
            cmd.inc_d  = 1'b1;
            state_next = S_T_GO;
          end
        end
      end
      S_S_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_STEP;
        state_next    = S_S_WAIT;
      end
      S_S_WAIT: begin
        if (sts.div_done) begin
          cmd.btn_apply = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_N_WAIT || state == S_T_WAIT || state == S_S_WAIT))
    else $error("Divider finished outside a wait state.");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input accepted twice without producing a result.");

endmodule

// ===== rtl/core/pwm_period_search_and_button_duty_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_search_and_button_duty_step_unit
// PWM prescaler/period search with a two-button duty step.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Content
// s_axis   in         s_tvalid / s_tready  start or button port sample
// m_axis   out        m_tvalid / m_tready  prescaler, period, duty, fail flag
// cfg      in         cfg_valid/cfg_ready  frequency and step divisor writes
//
// One item is in flight at a time. Each divide runs on the shared divider, whose
// dividend width is NW = max(17, clog2(CLOCK_HZ + 1)).
// A button sample needs a divide only when a duty step is applied.
// A start divides CLOCK_HZ by the frequency, then tries prescalers T from 1
// upward, at most 65535; a start with zero frequency goes straight to a failed result.
// Reset puts frequency and step divisor at 20 and clears all timer state.
// A waiting result stalls only the end of the next item, not its acceptance.
// ----------------------------------------------------------------------------
module pwm_period_search_and_button_duty_step_unit #(
  parameter int CLOCK_HZ  = pwmps_pkg::CLOCK_HZ_DEF,
  parameter int MAX_COUNT = pwmps_pkg::MAX_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // port_value[7:0]
  input  logic [0:0]                  s_tuser,   // req_type[0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // prescaler[15:0], period[31:16], duty[47:32], setup_failed[48], zeros
  output logic [pwmps_pkg::OUT_W-1:0] m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [15:0]                 cfg_data
);
  import pwmps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pwmps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .req_type(s_tuser[0]),
    .sts     (sts),
    .cmd     (cmd)
  );

  pwmps_dp #(.CLOCK_HZ(CLOCK_HZ), .MAX_COUNT(MAX_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .port_value(s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_ready   (m_tready),
    .m_valid   (m_tvalid),
    .m_data    (m_tdata)
  );

endmodule
